>>> src/ccr_pkg.sv
// Shared types and constants for the circle canvas rasterizer.
`timescale 1ns / 1ps
package ccr_pkg;
   localparam int DEF_MAX_W = 256;
   localparam int DEF_MAX_H = 256;
   localparam int COORD_W = 19;
   localparam int DIM_W = 9;
   localparam int CHAR_W = 8;
   localparam int CELL_W = 8;
   localparam int FIX_SHIFT = 8;
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BGCHAR = 2'd2;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_DRAW = 2'd2,
      CMD_READ = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [2*COORD_W-1:0] r2;
      logic [2*COORD_W-1:0] m2;
      logic m_neg;
      logic rim_only;
      logic [CHAR_W-1:0] ch;
      logic [CELL_W-1:0] row;
      logic [CELL_W-1:0] col;
      logic rd_in_range;
   } cmd_type;
endpackage

>>> src/ccr_front.sv
// Front end: accepts commands, squares the radius terms and queues classified work.
`timescale 1ns / 1ps
module ccr_front (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_op,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_center_y,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_radius,
   input  logic req_outline_only,
   input  logic [ccr_pkg::CHAR_W-1:0] req_paint_char,
   input  logic [ccr_pkg::CELL_W-1:0] req_cell_row,
   input  logic [ccr_pkg::CELL_W-1:0] req_cell_col,
   input  logic [ccr_pkg::DIM_W-1:0] used_w,
   input  logic [ccr_pkg::DIM_W-1:0] used_h,
   output logic rej_valid,
   output logic rej_status,
   output logic q_valid,
   output ccr_pkg::cmd_type q_cmd,
   input  logic q_pop
);
   import ccr_pkg::*;
   // Stage 1 holds the raw command; the squares are formed on the way into a two-entry queue.
   logic s1_ff, s1_in;
   logic [1:0] op_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, r_ff;
   logic ro_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic [CELL_W-1:0] row_ff, col_ff;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type q_ff [2];
   cmd_type c;
   logic signed [COORD_W:0] m;
   logic push, rej;

   assign busy = s1_ff || (cnt_ff != 2'd0);
   assign s1_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) s1_ff <= 1'b0;
      else s1_ff <= s1_in;
      if (s1_in) begin
         op_ff <= req_op; cx_ff <= req_center_x; cy_ff <= req_center_y;
         r_ff <= req_radius; ro_ff <= req_outline_only; ch_ff <= req_paint_char;
         row_ff <= req_cell_row; col_ff <= req_cell_col;
      end
   end

   always_comb begin
      m = {r_ff[COORD_W-1], r_ff} - (COORD_W+1)'(1 << FIX_SHIFT);
      c.cx = cx_ff; c.cy = cy_ff;
      c.r2 = (2*COORD_W)'(r_ff * r_ff);
      c.m2 = (2*COORD_W)'(m * m);
      c.m_neg = m[COORD_W];
      c.rim_only = ro_ff; c.ch = ch_ff; c.row = row_ff; c.col = col_ff;
      c.rd_in_range = ({1'b0, row_ff} < used_h) && ({1'b0, col_ff} < used_w);
      rej = 1'b0;
      case (op_ff)
         OP_CLEAR: c.kind = CMD_CLEAR;
         OP_DRAW: begin
            c.kind = CMD_DRAW;
            rej = r_ff[COORD_W-1] || (r_ff == '0);
            if (rej) c.kind = CMD_NONE;
         end
         OP_READ: c.kind = CMD_READ;
         default: c.kind = CMD_NONE;
      endcase
   end

   assign push = s1_ff && !rej;
   assign rej_valid = s1_ff && rej;
   assign rej_status = 1'b1;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !q_pop) cnt_in = cnt_ff + 2'd1;
      else if (!push && q_pop) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      if (push && (q_pop ? (cnt_ff == 2'd1) : (cnt_ff == 2'd0))) q_ff[0] <= c;
      else if (q_pop) q_ff[0] <= q_ff[1];
      if (push && (q_pop ? (cnt_ff == 2'd2) : (cnt_ff == 2'd1))) q_ff[1] <= c;
   end

   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd = q_ff[0];
endmodule

>>> src/ccr_back.sv
// Back end: sweeps the canvas memory for clear and draw, and serves cell reads.
`timescale 1ns / 1ps
module ccr_back #(
   parameter int MAX_W = ccr_pkg::DEF_MAX_W,
   parameter int MAX_H = ccr_pkg::DEF_MAX_H
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  ccr_pkg::cmd_type q_cmd,
   output logic q_pop,
   input  logic [ccr_pkg::DIM_W-1:0] used_w,
   input  logic [ccr_pkg::DIM_W-1:0] used_h,
   input  logic [ccr_pkg::CHAR_W-1:0] bg_char,
   output logic done_valid,
   output logic [ccr_pkg::CHAR_W-1:0] done_char
);
   import ccr_pkg::*;
   localparam int CW = (MAX_W > 1) ? $clog2(MAX_W) : 1;
   localparam int RW = (MAX_H > 1) ? $clog2(MAX_H) : 1;
   localparam int AW = CW + RW;
   localparam int DW = 2*COORD_W + 4;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_SWEEP = 4'b0010, ST_READ = 4'b0100, ST_DONE = 4'b1000
   } state_type;

   state_type st_ff, st_in;
   cmd_type cmd_ff;
   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [CHAR_W-1:0] mem [2**AW];
   logic [CHAR_W-1:0] rd_ff;
   logic rd_ok_ff;
   // Pipeline: stage a holds differences, stage b squares, stage c sums the squares and writes.
   logic a_v_ff, b_v_ff, c_v_ff;
   logic signed [COORD_W+DIM_W:0] dx_ff, dy_ff;
   logic [AW-1:0] a_addr_ff, b_addr_ff, c_addr_ff;
   logic [DW-1:0] dx2_ff, dy2_ff, d2_ff;
   logic last, pipe_busy, paint;
   logic [AW-1:0] addr_sw, addr_rd;

   assign last = (col_ff + DIM_W'(1) >= used_w) && (row_ff + DIM_W'(1) >= used_h);
   assign pipe_busy = a_v_ff || b_v_ff || c_v_ff;
   assign addr_sw = {RW'(row_ff), CW'(col_ff)};
   assign addr_rd = {RW'(cmd_ff.row), CW'(cmd_ff.col)};
   assign q_pop = (st_ff == ST_IDLE) && q_valid;

   always_comb begin
      st_in = st_ff; col_in = col_ff; row_in = row_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) begin
            col_in = '0; row_in = '0;
            case (q_cmd.kind)
               CMD_CLEAR, CMD_DRAW:
                  st_in = (used_w == '0 || used_h == '0) ? ST_DONE : ST_SWEEP;
               CMD_READ: st_in = ST_READ;
               default: st_in = ST_DONE;
            endcase
         end
         ST_SWEEP: begin
            if (last) st_in = ST_DONE;
            else if (col_ff + DIM_W'(1) >= used_w) begin
               col_in = '0; row_in = row_ff + DIM_W'(1);
            end else col_in = col_ff + DIM_W'(1);
         end
         ST_READ: st_in = ST_DONE;
         ST_DONE: if (!pipe_busy) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; a_v_ff <= 1'b0; b_v_ff <= 1'b0; c_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         a_v_ff <= st_ff == ST_SWEEP;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
      col_ff <= col_in; row_ff <= row_in;
      if (q_pop) cmd_ff <= q_cmd;
      dx_ff <= $signed({1'b0, col_ff, 8'b0}) - (COORD_W+DIM_W+1)'(cmd_ff.cx);
      dy_ff <= $signed({1'b0, row_ff, 8'b0}) - (COORD_W+DIM_W+1)'(cmd_ff.cy);
      a_addr_ff <= addr_sw;
      dx2_ff <= DW'(dx_ff * dx_ff);
      dy2_ff <= DW'(dy_ff * dy_ff);
      b_addr_ff <= a_addr_ff;
      d2_ff <= dx2_ff + dy2_ff;
      c_addr_ff <= b_addr_ff;
   end

   always_comb begin
      logic in_disc, rim;
      in_disc = d2_ff <= DW'(cmd_ff.r2);
      rim = in_disc && (cmd_ff.m_neg || d2_ff > DW'(cmd_ff.m2));
      if (cmd_ff.kind == CMD_CLEAR) paint = 1'b1;
      else paint = cmd_ff.rim_only ? rim : in_disc;
   end

   always_ff @(posedge clock) begin
      if (c_v_ff && paint)
         mem[c_addr_ff] <= (cmd_ff.kind == CMD_CLEAR) ? bg_char : cmd_ff.ch;
      rd_ff <= mem[addr_rd];
      rd_ok_ff <= (st_ff == ST_READ) && cmd_ff.rd_in_range;
   end

   assign done_valid = (st_ff == ST_DONE) && !pipe_busy;
   assign done_char = rd_ok_ff ? rd_ff : '0;
endmodule

>>> src/circle_canvas_rasterizer.sv
// Top level of the circle canvas rasterizer: registers, front end and back end.
`timescale 1ns / 1ps
// A clear or draw sweeps the canvas in use one cell per cycle through a three-stage
// distance pipeline into the canvas memory. A rejected draw is answered by the front end
// and never reaches the back end. busy stays high until the result transfer, so the next
// command can be taken in the cycle after it. The result is shown for one cycle on
// rsp_valid and cannot be stalled.
module circle_canvas_rasterizer #(
   parameter int MAX_W = ccr_pkg::DEF_MAX_W,
   parameter int MAX_H = ccr_pkg::DEF_MAX_H
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_op,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_center_y,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_radius,
   input  logic req_outline_only,
   input  logic [ccr_pkg::CHAR_W-1:0] req_paint_char,
   input  logic [ccr_pkg::CELL_W-1:0] req_cell_row,
   input  logic [ccr_pkg::CELL_W-1:0] req_cell_col,
   output logic rsp_valid,
   output logic rsp_status,
   output logic [ccr_pkg::CHAR_W-1:0] rsp_cell_char,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [ccr_pkg::DIM_W-1:0] csr_wdata
);
   import ccr_pkg::*;
   logic [DIM_W-1:0] w_ff, h_ff, used_w, used_h;
   logic [CHAR_W-1:0] bg_ff;
   logic fbusy, rej_valid, rej_status, q_valid, q_pop, done_valid;
   logic [CHAR_W-1:0] done_char;
   cmd_type q_cmd;
   logic pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= DIM_W'(1); h_ff <= DIM_W'(1); bg_ff <= CHAR_W'(32);
      end else if (csr_we) begin
         case (csr_index)
            REG_WIDTH: w_ff <= csr_wdata;
            REG_HEIGHT: h_ff <= csr_wdata;
            REG_BGCHAR: bg_ff <= csr_wdata[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   assign used_w = (int'(w_ff) > MAX_W) ? DIM_W'(MAX_W) : w_ff;
   assign used_h = (int'(h_ff) > MAX_H) ? DIM_W'(MAX_H) : h_ff;

   ccr_front u_front (
      .clock, .reset, .start(start && !pend_ff), .busy(fbusy), .req_op, .req_center_x,
      .req_center_y, .req_radius, .req_outline_only, .req_paint_char, .req_cell_row,
      .req_cell_col, .used_w, .used_h, .rej_valid, .rej_status, .q_valid, .q_cmd, .q_pop
   );

   ccr_back #(.MAX_W(MAX_W), .MAX_H(MAX_H)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop, .used_w, .used_h, .bg_char(bg_ff),
      .done_valid, .done_char
   );

   assign pend_in = (start && !busy) ? 1'b1 : ((rej_valid || done_valid) ? 1'b0 : pend_ff);
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else pend_ff <= pend_in;
   end

   assign busy = fbusy || pend_ff;
   assign rsp_valid = rej_valid || done_valid;
   assign rsp_status = rej_valid && rej_status;
   assign rsp_cell_char = rej_valid ? '0 : done_char;
endmodule
